### design/first_fit_allocator_assert.svh
// Assertion macros for the first-fit allocator
`ifndef FIRST_FIT_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, clocked on clk, off during reset
`define FFA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ffa assertion failed");
// Next-cycle implication
`define FFA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ffa assertion failed");
`else
`define FFA_ASSERT_IMP(lbl, ante, cons)
`define FFA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### design/ffa_pkg.sv
// Types and constants shared by the first-fit allocator
package ffa_pkg;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_GAP    = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] alloc_size;
    logic [15:0] free_address;
  } ffa_in_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] payload_address;
  } ffa_out_t;

  // One table entry: header offset and payload length
  typedef struct packed {
    logic [15:0] start;
    logic [15:0] length;
  } entry_t;

  // Register indexes
  localparam logic [1:0] CFG_POOL_LIMIT    = 2'd0;
  localparam logic [1:0] CFG_BASE_OFFSET   = 2'd1;
  localparam logic [1:0] CFG_NODE_OVERHEAD = 2'd2;

  // Extent end: 16-bit start + 8-bit overhead + 16-bit length
  localparam int PE_W  = 18;
  // Extent end plus overhead plus size
  localparam int SUM_W = 19;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_UP_RD,
    S_UP_WR,
    S_INSERT,
    S_DN_RD,
    S_DN_WR
  } state_t;

endpackage

### design/ffa_table.sv
// Allocation table memory: one write port, one registered read port
module ffa_table #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  ffa_pkg::entry_t wr_entry,
  input  logic            rd_en,
  input  logic [IDX_W-1:0] rd_idx,
  output ffa_pkg::entry_t rd_entry
);
  import ffa_pkg::*;

  entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_entry;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_entry <= mem[rd_idx];
    end
  end

endmodule

### design/first_fit_allocator.sv
// First-fit allocator: one request at a time; busy is high from the accepting edge to the result.
// The scan reads and then checks each entry in turn; the tail is shifted up (alloc) or down (free)
// with a read step and a write step per entry moved. An alloc ends by writing the new entry.
// A full-table alloc is answered directly from idle, without busy going high.
// Next beat can be taken at the strobe; no result stall.
// Reset clears the live count and loads register defaults; table contents stay undefined.
module first_fit_allocator #(
  parameter int MAX_REGIONS = 16,
  parameter int ADDR_BITS   = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  ffa_pkg::ffa_in_t in_data,
  output logic             out_valid,
  output ffa_pkg::ffa_out_t out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_idx,
  input  logic [15:0]      cfg_wdata
);
  import ffa_pkg::*;

  localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CNT_W = $clog2(MAX_REGIONS + 1);
  localparam int LIM_W = (ADDR_BITS < 16) ? ADDR_BITS : 16;

  // configuration registers
  logic [15:0] pool_limit_r;
  logic [7:0]  base_offset_r;
  logic [7:0]  node_overhead_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_limit_r    <= 16'd4096;
      base_offset_r   <= 8'd16;
      node_overhead_r <= 8'd32;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_POOL_LIMIT:    pool_limit_r    <= cfg_wdata;
        CFG_BASE_OFFSET:   base_offset_r   <= cfg_wdata[7:0];
        CFG_NODE_OVERHEAD: node_overhead_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // control and request registers
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  slot_r, slot_nxt;
  logic [PE_W-1:0]   prev_end_r, prev_end_nxt;
  op_t               op_r, op_nxt;
  logic [15:0]       size_r, size_nxt;
  logic [15:0]       addr_r, addr_nxt;
  logic              out_valid_r, out_valid_nxt;
  ffa_out_t          res_r, res_nxt;

  // table port
  logic             wr_en, rd_en;
  logic [IDX_W-1:0] wr_idx, rd_idx;
  entry_t           wr_entry, rd_entry;

  ffa_table #(.DEPTH(MAX_REGIONS), .IDX_W(IDX_W)) u_table (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_idx   (wr_idx),
    .wr_entry (wr_entry),
    .rd_en    (rd_en),
    .rd_idx   (rd_idx),
    .rd_entry (rd_entry)
  );

  // gap and match arithmetic
  logic [SUM_W-1:0] need, fit_sum, limit, ext_end, hdr_addr, pay_addr;
  logic [CNT_W-1:0] idx_m1, idx_p1;

  assign need     = SUM_W'(node_overhead_r) + SUM_W'(size_r);
  assign fit_sum  = SUM_W'(prev_end_r) + need;
  assign limit    = SUM_W'(pool_limit_r[LIM_W-1:0]);
  assign ext_end  = SUM_W'(rd_entry.start) + SUM_W'(node_overhead_r) + SUM_W'(rd_entry.length);
  assign hdr_addr = SUM_W'(rd_entry.start) + SUM_W'(node_overhead_r);
  assign pay_addr = SUM_W'(prev_end_r) + SUM_W'(node_overhead_r);
  assign idx_m1   = idx_r - 1'b1;
  assign idx_p1   = idx_r + 1'b1;

  // next state and datapath
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    slot_nxt      = slot_r;
    prev_end_nxt  = prev_end_r;
    op_nxt        = op_r;
    size_nxt      = size_r;
    addr_nxt      = addr_r;
    out_valid_nxt = 1'b0;
    res_nxt       = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt       = in_data.op;
          size_nxt     = in_data.alloc_size;
          addr_nxt     = in_data.free_address;
          idx_nxt      = '0;
          prev_end_nxt = PE_W'(base_offset_r);
          if (in_data.op == OP_ALLOC && count_r == CNT_W'(MAX_REGIONS)) begin
            out_valid_nxt = 1'b1;
            res_nxt       = '{status: ST_FULL, payload_address: 16'd0};
          end else begin
            state_nxt = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: begin
        if (idx_r == count_r) begin
          // end of table
          if (op_r == OP_ALLOC && fit_sum <= limit) begin
            slot_nxt  = count_r;
            state_nxt = S_UP_RD;
          end else begin
            out_valid_nxt = 1'b1;
            res_nxt       = '{status: (op_r == OP_ALLOC) ? ST_NO_GAP : ST_NOT_FOUND,
                              payload_address: 16'd0};
            state_nxt     = S_IDLE;
          end
        end else begin
          state_nxt = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (op_r == OP_ALLOC) begin
          if (fit_sum <= SUM_W'(rd_entry.start)) begin
            slot_nxt  = idx_r;
            idx_nxt   = count_r;
            state_nxt = S_UP_RD;
          end else begin
            prev_end_nxt = ext_end[PE_W-1:0];
            idx_nxt      = idx_p1;
            state_nxt    = S_SCAN_RD;
          end
        end else begin
          if (hdr_addr == SUM_W'(addr_r)) begin
            state_nxt = S_DN_RD;
          end else begin
            idx_nxt   = idx_p1;
            state_nxt = S_SCAN_RD;
          end
        end
      end
      S_UP_RD: begin
        state_nxt = (idx_r == slot_r) ? S_INSERT : S_UP_WR;
      end
      S_UP_WR: begin
        idx_nxt   = idx_m1;
        state_nxt = S_UP_RD;
      end
      S_INSERT: begin
        count_nxt     = count_r + 1'b1;
        out_valid_nxt = 1'b1;
        res_nxt       = '{status: ST_OK, payload_address: pay_addr[15:0]};
        state_nxt     = S_IDLE;
      end
      S_DN_RD: begin
        if (idx_p1 == count_r) begin
          count_nxt     = count_r - 1'b1;
          out_valid_nxt = 1'b1;
          res_nxt       = '{status: ST_OK, payload_address: 16'd0};
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_DN_WR;
        end
      end
      S_DN_WR: begin
        idx_nxt   = idx_p1;
        state_nxt = S_DN_RD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // table access per state; reads and writes never hit the same entry in one step
  always_comb begin
    rd_en    = 1'b0;
    rd_idx   = idx_r[IDX_W-1:0];
    wr_en    = 1'b0;
    wr_idx   = idx_r[IDX_W-1:0];
    wr_entry = rd_entry;
    unique case (state_r)
      S_SCAN_RD: rd_en = (idx_r != count_r);
      S_UP_RD: begin
        rd_en  = (idx_r != slot_r);
        rd_idx = idx_m1[IDX_W-1:0];
      end
      S_UP_WR: wr_en = 1'b1;
      S_INSERT: begin
        wr_en    = 1'b1;
        wr_idx   = slot_r[IDX_W-1:0];
        wr_entry = '{start: prev_end_r[15:0], length: size_r};
      end
      S_DN_RD: begin
        rd_en  = (idx_p1 != count_r);
        rd_idx = idx_p1[IDX_W-1:0];
      end
      S_DN_WR: wr_en = 1'b1;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    slot_r     <= slot_nxt;
    prev_end_r <= prev_end_nxt;
    op_r       <= op_nxt;
    size_r     <= size_nxt;
    addr_r     <= addr_nxt;
    res_r      <= res_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = res_r;

`include "first_fit_allocator_assert.svh"

  `FFA_ASSERT_IMP(a_count_max, 1'b1, count_r <= CNT_W'(MAX_REGIONS))
  `FFA_ASSERT_IMP(a_beat_idle, out_valid_r, !busy)
  `FFA_ASSERT_NXT(a_accept_resp, start && !busy, out_valid_r || busy)
  `FFA_ASSERT_IMP(a_wr_busy, wr_en, busy)

endmodule

### tb/sv/testbench.sv
// Testbench for the first-fit allocator: directed table, register changes and extremes, then random alloc/free traffic
`timescale 1ns / 100ps

module testbench;
  import ffa_pkg::*;

  localparam int NREG = 16;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  ffa_in_t  in_data;
  logic     out_valid;
  ffa_out_t out_data;
  logic       cfg_we;
  logic [1:0] cfg_idx;
  logic [15:0] cfg_wdata;

  first_fit_allocator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  // Predictor state: register copies and sorted live table
  logic [15:0] m_limit;
  logic [7:0]  m_base;
  logic [7:0]  m_ovh;
  logic [15:0] m_start [NREG];
  logic [15:0] m_len   [NREG];
  int          m_count;

  ffa_out_t pending_results[$];
  int       errors;
  int       stall_pct;
  logic [15:0] live_addrs[$];

  initial begin
    clk = 1'b0;
  end
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Allocator prediction for one request
  function automatic ffa_out_t predict_alloc(ffa_in_t req);
    ffa_out_t r;
    logic [18:0] prev_end;
    logic [18:0] need;
    int slot;
    bit found;
    prev_end = m_base;
    need = m_ovh + req.alloc_size;
    slot = 0;
    found = 0;
    r.status = ST_OK;
    r.payload_address = '0;
    if (req.op == OP_ALLOC) begin
      if (m_count >= NREG) begin
        r.status = ST_FULL;
        return r;
      end
      for (int i = 0; i < m_count; i++) begin
        if (!found) begin
          if (prev_end + need <= m_start[i]) begin
            slot = i;
            found = 1;
          end else begin
            prev_end = m_start[i] + m_ovh + m_len[i];
          end
        end
      end
      if (!found && prev_end + need <= m_limit) begin
        slot = m_count;
        found = 1;
      end
      if (!found) begin
        r.status = ST_NO_GAP;
        return r;
      end
      for (int i = m_count; i > slot; i--) begin
        m_start[i] = m_start[i-1];
        m_len[i] = m_len[i-1];
      end
      m_start[slot] = prev_end[15:0];
      m_len[slot] = req.alloc_size;
      m_count++;
      r.payload_address = 16'(prev_end + m_ovh);
    end else begin
      r.status = ST_NOT_FOUND;
      for (int i = 0; i < m_count; i++) begin
        if (r.status == ST_NOT_FOUND && (18'(m_start[i]) + m_ovh) == req.free_address) begin
          for (int j = i; j + 1 < m_count; j++) begin
            m_start[j] = m_start[j+1];
            m_len[j] = m_len[j+1];
          end
          m_count--;
          r.status = ST_OK;
        end
      end
    end
    return r;
  endfunction

  // Result checker: one expectation per strobe
  always @(posedge clk) begin
    ffa_out_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_data.status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, out_data.status);
          errors++;
        end
        if (out_data.payload_address !== e.payload_address) begin
          $display("%0t: address expected %h actual %h", $time, e.payload_address,
                   out_data.payload_address);
          errors++;
        end
        if (e.status == ST_OK && e.payload_address != 0) live_addrs.push_back(e.payload_address);
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_POOL_LIMIT:    m_limit = val;
      CFG_BASE_OFFSET:   m_base = val[7:0];
      CFG_NODE_OVERHEAD: m_ovh = val[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Wait until every result is back, then settle
  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Send one beat; chk marks a typed-in expectation
  task automatic send_req(ffa_in_t req, bit chk, ffa_out_t want);
    ffa_out_t p;
    while ($urandom_range(99) < stall_pct) @(posedge clk);
    start <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    p = predict_alloc(req);
    if (chk && p !== want) begin
      $display("%0t: table row expected %h predicted %h", $time, want, p);
      errors++;
    end
    pending_results.push_back(p);
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic ffa_in_t mk(op_t op, logic [15:0] sz, logic [15:0] ad);
    ffa_in_t r;
    r.op = op;
    r.alloc_size = sz;
    r.free_address = ad;
    return r;
  endfunction

  function automatic ffa_out_t res(status_t s, logic [15:0] a);
    ffa_out_t r;
    r.status = s;
    r.payload_address = a;
    return r;
  endfunction

  typedef struct {
    ffa_in_t  req;
    bit       chk;
    ffa_out_t want;
  } row_t;

  initial begin
    row_t rows[$];
    ffa_in_t q;
    int k;
    errors = 0;
    stall_pct = 34;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    m_limit = 16'd4096;
    m_base = 8'd16;
    m_ovh = 8'd32;
    m_count = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows at reset settings
    rows.push_back('{mk(OP_FREE, 16'h0, 16'd48), 1, res(ST_NOT_FOUND, 0)});
    rows.push_back('{mk(OP_ALLOC, 16'd100, 16'hffff), 1, res(ST_OK, 16'd48)});
    rows.push_back('{mk(OP_ALLOC, 16'hffff, 16'h0), 1, res(ST_NO_GAP, 0)});
    rows.push_back('{mk(OP_ALLOC, 16'd0, 16'h0), 1, res(ST_OK, 16'd180)});
    rows.push_back('{mk(OP_FREE, 16'hffff, 16'd48), 1, res(ST_OK, 0)});
    rows.push_back('{mk(OP_ALLOC, 16'd50, 16'h0), 0, '0});
    rows.push_back('{mk(OP_ALLOC, 16'd200, 16'h0), 0, '0});
    rows.push_back('{mk(OP_FREE, 16'h0, 16'hffff), 1, res(ST_NOT_FOUND, 0)});
    rows.push_back('{mk(OP_FREE, 16'h0, 16'd180), 0, '0});
    for (int i = 0; i < 15; i++) rows.push_back('{mk(OP_ALLOC, 16'd1, 16'h0), 0, '0});
    rows.push_back('{mk(OP_ALLOC, 16'd1, 16'h0), 1, res(ST_FULL, 0)});
    foreach (rows[i]) send_req(rows[i].req, rows[i].chk, rows[i].want);
    drain();

    // Register changes with entries live, then the extremes
    write_reg(CFG_NODE_OVERHEAD, 16'd0);
    send_req(mk(OP_FREE, 0, 16'd48), 0, '0);
    send_req(mk(OP_FREE, 0, m_start[0]), 0, '0);
    drain();
    write_reg(CFG_NODE_OVERHEAD, 16'd255);
    write_reg(CFG_BASE_OFFSET, 16'd255);
    write_reg(CFG_POOL_LIMIT, 16'hffff);
    while (m_count > 0) send_req(mk(OP_FREE, 0, m_start[0] + 16'd255), 0, '0);
    send_req(mk(OP_ALLOC, 16'hffff, 0), 0, '0);
    send_req(mk(OP_ALLOC, 16'd64770, 0), 0, '0);
    send_req(mk(OP_FREE, 0, 16'd510), 0, '0);
    drain();
    write_reg(CFG_POOL_LIMIT, 16'd0);
    write_reg(CFG_BASE_OFFSET, 16'd0);
    send_req(mk(OP_ALLOC, 16'd0, 0), 0, '0);
    drain();

    // Random phases over several settings
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_POOL_LIMIT, (ph == 7) ? 16'hffff : 16'($urandom_range(65535)));
      write_reg(CFG_BASE_OFFSET, 16'($urandom_range(255)));
      write_reg(CFG_NODE_OVERHEAD, (ph == 0) ? 16'd0 : 16'($urandom_range(255)));
      stall_pct = (ph == 3) ? 0 : 34;
      live_addrs.delete();
      for (int n = 0; n < 50; n++) begin
        k = $urandom_range(99);
        if (k < 50) begin
          q = mk(OP_ALLOC, ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(600)),
                 16'($urandom));
        end else if (k < 85 && m_count > 0) begin
          q = mk(OP_FREE, 16'($urandom),
                 m_start[$urandom_range(m_count - 1)] + m_ovh);
        end else begin
          q = mk(OP_FREE, 16'($urandom), 16'($urandom));
        end
        send_req(q, 0, '0);
      end
      drain();
    end

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Overall time limit
  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/ffa_pkg.sv
design/ffa_table.sv
design/first_fit_allocator.sv
tb/sv/testbench.sv
